FILE: rtl/accel_tilt_and_temperature_macros.svh
// ----------------------------------------------------------------------------
// accel_tilt_and_temperature_macros.svh
// Assertion macros shared by the tilt/temperature checker.
// ----------------------------------------------------------------------------
`ifndef ACCEL_TILT_AND_TEMPERATURE_MACROS_SVH
`define ACCEL_TILT_AND_TEMPERATURE_MACROS_SVH

// same-cycle implication, disabled during reset
`define ATT_ASSERT_IMPLY(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define ATT_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/att_pkg.sv
// ----------------------------------------------------------------------------
// att_pkg
// Shared constants, types and tables for the tilt/temperature pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package att_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int ATAN_ENTRIES  = 24;
  localparam int NUM_ITER      = (CORDIC_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STAGES;

  localparam int SQRT_CELLS = 32;
  localparam int FRONT_REGS = 3;
  localparam int NUM_PIPE   = FRONT_REGS + SQRT_CELLS + NUM_ITER;

  localparam int SQ_W   = 32;
  localparam int REM_W  = 34;
  localparam int ROOT_W = 32;
  localparam int CW     = 36;
  localparam int AW     = 24;
  localparam int SH_W   = 5;

  localparam logic signed [AW-1:0] ANGLE_90  = 24'sd2304000;
  localparam logic [15:0]          ANGLE_MAX = 16'd18000;

  // floor((10*raw + 124219) / 34), offset by 6000*34 to stay positive
  localparam int             TEMP_W      = 20;
  localparam logic [24:0]    TEMP_MUL    = 25'd31580642;
  localparam int             TEMP_SHIFT  = 30;
  localparam int             TEMP_PROD_W = 45;
  localparam logic [14:0]    TEMP_BIAS   = 15'd6000;
  localparam logic signed [20:0] TEMP_OFFSET = 21'sd328219;

  typedef struct packed {
    logic              angle_valid;
    logic signed [14:0] temp_centi;
  } side_t;

  // atan(2^-i) in units of 1/25600 degree
  function automatic logic signed [AW-1:0] atan_entry(input int i);
    logic signed [AW-1:0] v;
    case (i)
      0:       v = 24'sd1152000;
      1:       v = 24'sd680065;
      2:       v = 24'sd359328;
      3:       v = 24'sd182400;
      4:       v = 24'sd91554;
      5:       v = 24'sd45822;
      6:       v = 24'sd22916;
      7:       v = 24'sd11459;
      8:       v = 24'sd5730;
      9:       v = 24'sd2865;
      10:      v = 24'sd1432;
      11:      v = 24'sd716;
      12:      v = 24'sd358;
      13:      v = 24'sd179;
      14:      v = 24'sd90;
      15:      v = 24'sd45;
      16:      v = 24'sd22;
      17:      v = 24'sd11;
      18:      v = 24'sd6;
      19:      v = 24'sd3;
      20:      v = 24'sd1;
      21:      v = 24'sd1;
      default: v = 24'sd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/att_front.sv
// ----------------------------------------------------------------------------
// att_front
// Input registers, axis squares and temperature scaling ahead of the cells.
// ----------------------------------------------------------------------------
`default_nettype none

module att_front (
  input  wire                        clk,
  input  wire                        en,
  input  wire signed [15:0]          accel_x,
  input  wire signed [15:0]          accel_y,
  input  wire signed [15:0]          accel_z,
  input  wire signed [15:0]          temp_raw,
  output logic [att_pkg::SQ_W-1:0]   sq,
  output logic signed [15:0]         z_out,
  output att_pkg::side_t             side_out
);

  logic signed [15:0] x0, y0, z0, raw0;

  logic [30:0]                      xsq, ysq;
  logic signed [15:0]               z1;
  logic [att_pkg::TEMP_W-1:0]       tpos;
  logic                             av1;

  logic [att_pkg::TEMP_PROD_W-1:0]  tprod;
  logic                             av2;

  logic signed [31:0] xx_full, yy_full;
  logic signed [20:0] raw_ext, tsum;
  logic [14:0]        tq;

  assign xx_full = x0 * x0;
  assign yy_full = y0 * y0;
  assign raw_ext = 21'(raw0);
  assign tsum    = raw_ext * 21'sd10 + att_pkg::TEMP_OFFSET;

  always_ff @(posedge clk) begin
    if (en) begin
      x0    <= accel_x;
      y0    <= accel_y;
      z0    <= accel_z;
      raw0  <= temp_raw;

      xsq   <= xx_full[30:0];
      ysq   <= yy_full[30:0];
      z1    <= z0;
      tpos  <= tsum[att_pkg::TEMP_W-1:0];
      av1   <= (x0 != 16'sd0) || (y0 != 16'sd0) || (z0 != 16'sd0);

      sq    <= {1'b0, xsq} + {1'b0, ysq};
      z_out <= z1;
      tprod <= att_pkg::TEMP_PROD_W'(tpos) * att_pkg::TEMP_PROD_W'(att_pkg::TEMP_MUL);
      av2   <= av1;
    end
  end

  assign tq = tprod[att_pkg::TEMP_SHIFT +: 15];
  assign side_out.angle_valid = av2;
  assign side_out.temp_centi  = tq - att_pkg::TEMP_BIAS;

endmodule

`default_nettype wire

FILE: rtl/att_sqrt_cell.sv
// ----------------------------------------------------------------------------
// att_sqrt_cell
// One root bit of the pipelined square root (two radicand bits per cell).
// ----------------------------------------------------------------------------
`default_nettype none

module att_sqrt_cell (
  input  wire                          clk,
  input  wire                          en,
  input  wire [att_pkg::REM_W-1:0]     rem_in,
  input  wire [att_pkg::ROOT_W-1:0]    root_in,
  input  wire [att_pkg::SQ_W-1:0]      sq_in,
  input  wire signed [15:0]            z_in,
  input  att_pkg::side_t               side_in,
  output logic [att_pkg::REM_W-1:0]    rem_out,
  output logic [att_pkg::ROOT_W-1:0]   root_out,
  output logic [att_pkg::SQ_W-1:0]     sq_out,
  output logic signed [15:0]           z_out,
  output att_pkg::side_t               side_out
);

  logic [att_pkg::REM_W+1:0] cur, trial, diff;
  logic                      ge;

  assign cur   = {rem_in, sq_in[att_pkg::SQ_W-1 -: 2]};
  assign trial = {2'b00, root_in, 2'b01};
  assign ge    = (cur >= trial);
  assign diff  = cur - trial;

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out  <= ge ? diff[att_pkg::REM_W-1:0] : cur[att_pkg::REM_W-1:0];
      root_out <= {root_in[att_pkg::ROOT_W-2:0], ge};
      sq_out   <= {sq_in[att_pkg::SQ_W-3:0], 2'b00};
      z_out    <= z_in;
      side_out <= side_in;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/att_cordic_cell.sv
// ----------------------------------------------------------------------------
// att_cordic_cell
// One vectoring-mode CORDIC micro-rotation with its angle update.
// ----------------------------------------------------------------------------
`default_nettype none

module att_cordic_cell (
  input  wire                              clk,
  input  wire                              en,
  input  wire [att_pkg::SH_W-1:0]          shamt,
  input  wire signed [att_pkg::AW-1:0]     atan_val,
  input  wire signed [att_pkg::CW-1:0]     cx_in,
  input  wire signed [att_pkg::CW-1:0]     cy_in,
  input  wire signed [att_pkg::AW-1:0]     acc_in,
  input  att_pkg::side_t                   side_in,
  output logic signed [att_pkg::CW-1:0]    cx_out,
  output logic signed [att_pkg::CW-1:0]    cy_out,
  output logic signed [att_pkg::AW-1:0]    acc_out,
  output att_pkg::side_t                   side_out
);

  logic signed [att_pkg::CW-1:0] dx, dy;
  logic                          pos;

  assign dx  = cy_in >>> shamt;
  assign dy  = cx_in >>> shamt;
  assign pos = (cy_in > 0);

  always_ff @(posedge clk) begin
    if (en) begin
      cx_out   <= pos ? cx_in + dx : cx_in - dx;
      cy_out   <= pos ? cy_in - dy : cy_in + dy;
      acc_out  <= pos ? acc_in + atan_val : acc_in - atan_val;
      side_out <= side_in;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/accel_tilt_and_temperature.sv
// ----------------------------------------------------------------------------
// accel_tilt_and_temperature
// Tilt angle from the z axis and temperature conversion for one sample set.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_ready with accel_x/y/z and temp_raw. Output
// channel: out_valid/out_ready with tilt_angle (0.01 deg), angle_valid and
// temp_centi (0.01 deg C).
// The datapath is a fixed pipeline: three front registers (inputs, squares,
// sum and temperature scaling), 32 square-root cells (one root bit each) and
// CORDIC_STAGES rotation cells, then the output register.
// Throughput: one request per cycle while the skid register is empty.
// A two-entry output buffer (output register plus skid register) sits at the
// end. When out_ready is low, one more result lands in the skid register and
// then the whole pipeline holds; in_ready follows the skid register only.
// Reset clears all valid bits; payload registers are not reset.
// An all-zero vector gives tilt_angle 0 with angle_valid low.
// ----------------------------------------------------------------------------
`default_nettype none

module accel_tilt_and_temperature (
  input  wire                clk,
  input  wire                rst,
  input  wire                in_valid,
  output logic               in_ready,
  input  wire signed [15:0]  accel_x,
  input  wire signed [15:0]  accel_y,
  input  wire signed [15:0]  accel_z,
  input  wire signed [15:0]  temp_raw,
  output logic               out_valid,
  input  wire                out_ready,
  output logic [14:0]        tilt_angle,
  output logic               angle_valid,
  output logic signed [14:0] temp_centi
);

  localparam int NS = att_pkg::SQRT_CELLS;
  localparam int NC = att_pkg::NUM_ITER;
  localparam int NP = att_pkg::NUM_PIPE;

  logic          en;
  logic [NP-1:0] vld;

  logic [att_pkg::REM_W-1:0]  s_rem  [NS+1];
  logic [att_pkg::ROOT_W-1:0] s_root [NS+1];
  logic [att_pkg::SQ_W-1:0]   s_sq   [NS+1];
  logic signed [15:0]         s_z    [NS+1];
  att_pkg::side_t             s_side [NS+1];

  logic signed [att_pkg::CW-1:0] c_x   [NC+1];
  logic signed [att_pkg::CW-1:0] c_y   [NC+1];
  logic signed [att_pkg::AW-1:0] c_acc [NC+1];
  att_pkg::side_t                c_side[NC+1];

  logic signed [att_pkg::CW-1:0] r_ext, zs;
  logic signed [att_pkg::AW-1:0] acc_fin, acc_rnd;
  logic [15:0]                   t_rnd;
  logic [14:0]                   tilt_fin;

  logic               skid_valid;
  logic [14:0]        skid_tilt;
  logic               skid_av;
  logic signed [14:0] skid_temp;
  logic               push;

  assign en       = !skid_valid;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NP-2:0], in_valid};
    end
  end

  att_front u_front (
    .clk      (clk),
    .en       (en),
    .accel_x  (accel_x),
    .accel_y  (accel_y),
    .accel_z  (accel_z),
    .temp_raw (temp_raw),
    .sq       (s_sq[0]),
    .z_out    (s_z[0]),
    .side_out (s_side[0])
  );

  assign s_rem[0]  = '0;
  assign s_root[0] = '0;

  for (genvar k = 0; k < NS; k++) begin : g_sqrt
    att_sqrt_cell u_cell (
      .clk      (clk),
      .en       (en),
      .rem_in   (s_rem[k]),
      .root_in  (s_root[k]),
      .sq_in    (s_sq[k]),
      .z_in     (s_z[k]),
      .side_in  (s_side[k]),
      .rem_out  (s_rem[k+1]),
      .root_out (s_root[k+1]),
      .sq_out   (s_sq[k+1]),
      .z_out    (s_z[k+1]),
      .side_out (s_side[k+1])
    );
  end

  // prerotation: z < 0 turns the vector by -90 degrees
  assign r_ext = att_pkg::CW'(s_root[NS]);
  assign zs    = {{(att_pkg::CW-32){s_z[NS][15]}}, s_z[NS], 16'd0};

  assign c_x[0]    = s_z[NS][15] ? r_ext : zs;
  assign c_y[0]    = s_z[NS][15] ? -zs : r_ext;
  assign c_acc[0]  = s_z[NS][15] ? att_pkg::ANGLE_90 : '0;
  assign c_side[0] = s_side[NS];

  for (genvar i = 0; i < NC; i++) begin : g_cordic
    att_cordic_cell u_cell (
      .clk      (clk),
      .en       (en),
      .shamt    (att_pkg::SH_W'(i)),
      .atan_val (att_pkg::atan_entry(i)),
      .cx_in    (c_x[i]),
      .cy_in    (c_y[i]),
      .acc_in   (c_acc[i]),
      .side_in  (c_side[i]),
      .cx_out   (c_x[i+1]),
      .cy_out   (c_y[i+1]),
      .acc_out  (c_acc[i+1]),
      .side_out (c_side[i+1])
    );
  end

  assign acc_fin  = (c_acc[NC] < 0) ? '0 : c_acc[NC];
  assign acc_rnd  = (acc_fin + att_pkg::AW'(128)) >>> 8;
  assign t_rnd    = acc_rnd[15:0];
  assign tilt_fin = !c_side[NC].angle_valid ? 15'd0 :
                    (t_rnd > att_pkg::ANGLE_MAX) ? att_pkg::ANGLE_MAX[14:0] : t_rnd[14:0];

  assign push = en && vld[NP-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid  <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      if (skid_valid) begin
        tilt_angle  <= skid_tilt;
        angle_valid <= skid_av;
        temp_centi  <= skid_temp;
      end else begin
        tilt_angle  <= tilt_fin;
        angle_valid <= c_side[NC].angle_valid;
        temp_centi  <= c_side[NC].temp_centi;
      end
    end else if (push) begin
      skid_tilt <= tilt_fin;
      skid_av   <= c_side[NC].angle_valid;
      skid_temp <= c_side[NC].temp_centi;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/att_checker.sv
// ----------------------------------------------------------------------------
// att_checker
// Port-level checks on the tilt/temperature block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "accel_tilt_and_temperature_macros.svh"

module att_checker (
  input wire                clk,
  input wire                rst,
  input wire                in_ready,
  input wire                out_valid,
  input wire                out_ready,
  input wire [14:0]         tilt_angle,
  input wire                angle_valid,
  input wire signed [14:0]  temp_centi
);

  `ATT_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(tilt_angle) && $stable(angle_valid) && $stable(temp_centi), "output request changed while stalled")
  `ATT_ASSERT_IMPLY(a_tilt_range, clk, rst, out_valid, tilt_angle <= 15'd18000, "tilt angle above 180 degrees")
  `ATT_ASSERT_IMPLY(a_zero_vec, clk, rst, out_valid && !angle_valid, tilt_angle == 15'd0, "zero vector with nonzero angle")
  `ATT_ASSERT_IMPLY(a_temp_range, clk, rst, out_valid, (temp_centi >= -15'sd5985) && (temp_centi <= 15'sd13290), "temperature out of range")
  `ATT_ASSERT_NEXT(a_stall_accept, clk, rst, out_valid && !out_ready && !in_ready, !in_ready || out_ready, "input reopened while output stalled and buffer full")

endmodule

bind accel_tilt_and_temperature att_checker u_att_checker (.*);

`default_nettype wire

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the tilt angle and temperature pipeline.
// Directed corner cases, then about a thousand random sample sets, with
// random stalls on both channels and one long output hold-off that backs the
// pipeline up. Every result is checked in order against an in-bench model.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

  localparam int  LIMIT_CYCLES   = 200000;
  localparam int  RANDOM_COUNT   = 1000;
  localparam int  HOLD_AT        = 300;
  localparam int  HOLD_CYCLES    = 200;
  localparam int  DRAIN_CYCLES   = att_pkg::NUM_PIPE + 20;
  localparam int  TEMP_OFFSET_X2 = 62101;
  localparam longint RIGHT_ANGLE = 2304000;
  localparam longint MAX_CENTI   = 18000;
  localparam longint ATAN_UNITS [24] = '{
    1152000, 680065, 359328, 182400, 91554, 45822, 22916, 11459,
    5730, 2865, 1432, 716, 358, 179, 90, 45,
    22, 11, 6, 3, 1, 1, 0, 0
  };

  typedef struct {
    logic [14:0]        tilt;
    logic               valid;
    logic signed [14:0] temp;
  } reading_t;

  class tilt_temp_scoreboard;
    reading_t pending_readings[$];
    int       errors;

    function new();
      errors = 0;
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    function bit [63:0] int_sqrt(bit [63:0] n);
      bit [63:0] root;
      bit [63:0] probe;
      root  = 0;
      probe = 64'd1 << 62;
      while (probe > n) probe = probe >> 2;
      while (probe != 0) begin
        if (n >= root + probe) begin
          n    = n - (root + probe);
          root = (root >> 1) + probe;
        end else begin
          root = root >> 1;
        end
        probe = probe >> 2;
      end
      return root;
    endfunction

    function logic [14:0] tilt_centideg(longint x, longint y, longint z);
      bit [63:0] sq;
      longint    r, cx, cy, acc, dx, dy, t;
      int        i;
      sq = 64'(x * x) + 64'(y * y);
      r  = longint'(int_sqrt(sq << 32));
      if (z < 0) begin
        cx  = r;
        cy  = -(z * 65536);
        acc = RIGHT_ANGLE;
      end else begin
        cx  = z * 65536;
        cy  = r;
        acc = 0;
      end
      for (i = 0; i < att_pkg::NUM_ITER; i++) begin
        dx = cy >>> i;
        dy = cx >>> i;
        if (cy > 0) begin
          cx  = cx + dx;
          cy  = cy - dy;
          acc = acc + ATAN_UNITS[i];
        end else begin
          cx  = cx - dx;
          cy  = cy + dy;
          acc = acc - ATAN_UNITS[i];
        end
      end
      if (acc < 0) acc = 0;
      t = (acc + 128) >>> 8;
      if (t > MAX_CENTI) t = MAX_CENTI;
      return t[14:0];
    endfunction

    function logic signed [14:0] temp_centideg(longint raw);
      longint t;
      t = 2 * (5 * raw + TEMP_OFFSET_X2) + 17;
      if (t >= 0) return 15'(t / 34);
      return 15'(-((-t + 33) / 34));
    endfunction

    function void note_request(logic signed [15:0] x, logic signed [15:0] y,
                               logic signed [15:0] z, logic signed [15:0] raw);
      reading_t exp_reading;
      exp_reading.valid = (x != 0) || (y != 0) || (z != 0);
      exp_reading.tilt  = exp_reading.valid ?
                          tilt_centideg(longint'(x), longint'(y), longint'(z)) : 15'd0;
      exp_reading.temp  = temp_centideg(longint'(raw));
      pending_readings.push_back(exp_reading);
    endfunction

    task check_result(logic [14:0] tilt, logic valid, logic signed [14:0] temp);
      reading_t exp_reading;
      if (pending_readings.size() == 0) begin
        report("result with no request outstanding");
      end else begin
        exp_reading = pending_readings.pop_front();
        if (tilt !== exp_reading.tilt)
          report($sformatf("tilt_angle %0d, expected %0d", tilt, exp_reading.tilt));
        if (valid !== exp_reading.valid)
          report($sformatf("angle_valid %0b, expected %0b", valid, exp_reading.valid));
        if (temp !== exp_reading.temp)
          report($sformatf("temp_centi %0d, expected %0d", temp, exp_reading.temp));
      end
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [15:0] accel_x = '0;
  logic signed [15:0] accel_y = '0;
  logic signed [15:0] accel_z = '0;
  logic signed [15:0] temp_raw = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [14:0]        tilt_angle;
  logic               angle_valid;
  logic signed [14:0] temp_centi;

  tilt_temp_scoreboard sb = new();
  int  requests_sent = 0;
  bit  calm = 1'b0;
  int  cycles = 0;

  accel_tilt_and_temperature dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .accel_x    (accel_x),
    .accel_y    (accel_y),
    .accel_z    (accel_z),
    .temp_raw   (temp_raw),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .tilt_angle (tilt_angle),
    .angle_valid(angle_valid),
    .temp_centi (temp_centi)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("[accel_tilt_and_temperature] ERROR");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result(tilt_angle, angle_valid, temp_centi);
  end

  // output side: random stalls, one long hold-off, none while calm
  initial begin
    bit held_off;
    held_off = 1'b0;
    forever begin
      if (!held_off && requests_sent >= HOLD_AT) begin
        held_off = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (calm) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else if ($urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  task automatic send_sample(input logic signed [15:0] x, input logic signed [15:0] y,
                             input logic signed [15:0] z, input logic signed [15:0] raw);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1'b1;
    accel_x  <= x;
    accel_y  <= y;
    accel_z  <= z;
    temp_raw <= raw;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(x, y, z, raw);
    requests_sent++;
  endtask

  function automatic logic signed [15:0] near_g();
    int v;
    v = $urandom_range(0, 1) ? 16384 : -16384;
    return 16'(v + int'($urandom_range(0, 4000)) - 2000);
  endfunction

  task automatic send_random_sample();
    logic signed [15:0] x, y, z, raw;
    int mode;
    mode = $urandom_range(0, 49);
    raw  = 16'($urandom_range(0, 65535));
    if (mode == 0) begin
      x = 0; y = 0; z = 0;
    end else if (mode < 20) begin
      x = 16'($urandom_range(0, 65535));
      y = 16'($urandom_range(0, 65535));
      z = 16'($urandom_range(0, 65535));
    end else if (mode < 30) begin
      x = 16'(int'($urandom_range(0, 128)) - 64);
      y = 16'(int'($urandom_range(0, 128)) - 64);
      z = 16'(int'($urandom_range(0, 128)) - 64);
    end else if (mode < 42) begin
      x = 16'(int'($urandom_range(0, 8000)) - 4000);
      y = 16'(int'($urandom_range(0, 8000)) - 4000);
      z = near_g();
      if ($urandom_range(0, 2) == 0) begin
        z = x;
        x = near_g();
      end
    end else begin
      x = $urandom_range(0, 1) ? 16'($urandom_range(0, 65535)) : 16'sd0;
      y = $urandom_range(0, 1) ? 16'($urandom_range(0, 65535)) : 16'sd0;
      z = $urandom_range(0, 1) ? 16'($urandom_range(0, 65535)) : 16'sd0;
    end
    send_sample(x, y, z, raw);
  endtask

  initial begin
    int n;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // corner cases: zero vector, poles, axes, sign extremes, temp limits
    send_sample(16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_sample(16'sd0, 16'sd0, 16'sd0, 16'sh7fff);
    send_sample(16'sd0, 16'sd0, 16'sd16384, -16'sd32768);
    send_sample(16'sd0, 16'sd0, -16'sd16384, 16'sh7fff);
    send_sample(16'sd16384, 16'sd0, 16'sd0, -16'sd1);
    send_sample(16'sd0, -16'sd16384, 16'sd0, 16'sd1);
    send_sample(16'sh7fff, 16'sh7fff, 16'sh7fff, -16'sd12420);
    send_sample(-16'sd32768, -16'sd32768, -16'sd32768, 16'sd0);
    send_sample(-16'sd32768, 16'sd0, 16'sd0, 16'sd340);
    send_sample(16'sd0, 16'sd0, -16'sd32768, -16'sd340);
    send_sample(16'sd0, 16'sd0, 16'sh7fff, 16'sd5000);
    send_sample(16'sd1, 16'sd0, 16'sd0, 16'sd2);
    send_sample(16'sd0, 16'sd1, 16'sd0, -16'sd2);
    send_sample(16'sd0, 16'sd0, 16'sd1, 16'sd17);
    send_sample(16'sd0, 16'sd0, -16'sd1, -16'sd17);
    send_sample(-16'sd1, 16'sd0, 16'sd0, 16'sd0);
    send_sample(16'sd1, 16'sd1, -16'sd1, 16'sd0);
    send_sample(16'sd11585, 16'sd0, 16'sd11585, 16'sd100);
    send_sample(16'sd16384, 16'sd0, -16'sd16384, -16'sd100);
    send_sample(16'sh7fff, -16'sd32768, 16'sd1, 16'sh5555);
    send_sample(16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa);
    send_sample(16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555);

    for (n = 0; n < RANDOM_COUNT; n++) begin
      calm = (n >= 500 && n < 600) || (n >= RANDOM_COUNT - 150);
      send_random_sample();
    end
    in_valid <= 1'b0;

    while (sb.pending_readings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0)
      $display("[accel_tilt_and_temperature] OK");
    else
      $display("[accel_tilt_and_temperature] ERROR");
    $finish;
  end

endmodule

`default_nettype wire
